// File: rtl/gdo_pkg.sv
// Package: shared types, constants, calendar tables and microprogram of the date offset unit.
`timescale 1ns / 1ps

package gdo_pkg;

    // Field widths of the item and result words
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 16;
    localparam int WDAY_W   = 3;

    // Internal working widths: day count, signed year, century, remainder, Zeller sum, quotient
    localparam int DACC_W = 17;
    localparam int YACC_W = 15;
    localparam int CENT_W = 9;
    localparam int REM_W  = 7;
    localparam int ZSUM_W = 10;
    localparam int ZQ_W   = 7;

    localparam int PC_W = 4;

    localparam logic signed [YACC_W-1:0] YEAR_MIN = 15'sd1;
    localparam logic signed [YACC_W-1:0] YEAR_MAX = 15'sd9999;
    localparam logic [MONTH_W-1:0]       MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0]       MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0]       MONTH_DEC = 4'd12;
    localparam logic [REM_W-1:0]         REM_MAX   = 7'd99;

    // floor(y / 100) = (y * RECIP_100) >> RECIP_100_SH for y below 16384
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          RECIP_100_SH = 19;
    // floor(s / 7) = (s * RECIP_7) >> RECIP_7_SH for s below 1024
    localparam logic [11:0] RECIP_7      = 12'd2341;
    localparam int          RECIP_7_SH   = 14;
    localparam logic [6:0]  CENTURY      = 7'd100;
    localparam logic [3:0]  WEEK         = 4'd7;
    localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd6;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIVC,
        OP_MODR,
        OP_CHECK,
        OP_ADD,
        OP_FWD,
        OP_BWD,
        OP_CLAMP,
        OP_ZPREP,
        OP_ZSUM1,
        OP_ZSUM2,
        OP_ZMUL,
        OP_ZMOD,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_INVALID,
        C_FWD,
        C_BWD,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
        logic             last;
    } t_ctrl;

    typedef struct packed {
        logic bad;
        logic fwd;
        logic bwd;
    } t_status;

    typedef struct packed {
        logic [DAY_W-1:0]           day;
        logic [MONTH_W-1:0]         month;
        logic [YEAR_W-1:0]          year;
        logic signed [OFFSET_W-1:0] offset;
    } t_item;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [WDAY_W-1:0]  weekday;
        logic               date_valid;
        logic               year_overflow;
    } t_result;

    // Step addresses of the microprogram
    localparam logic [PC_W-1:0] ST_DIVC  = 4'd0;
    localparam logic [PC_W-1:0] ST_MODR  = 4'd1;
    localparam logic [PC_W-1:0] ST_CHECK = 4'd2;
    localparam logic [PC_W-1:0] ST_ADD   = 4'd3;
    localparam logic [PC_W-1:0] ST_FWD   = 4'd4;
    localparam logic [PC_W-1:0] ST_BWD   = 4'd5;
    localparam logic [PC_W-1:0] ST_CLAMP = 4'd6;
    localparam logic [PC_W-1:0] ST_ZPREP = 4'd7;
    localparam logic [PC_W-1:0] ST_ZSUM1 = 4'd8;
    localparam logic [PC_W-1:0] ST_ZSUM2 = 4'd9;
    localparam logic [PC_W-1:0] ST_ZMUL  = 4'd10;
    localparam logic [PC_W-1:0] ST_ZMOD  = 4'd11;
    localparam logic [PC_W-1:0] ST_EMIT  = 4'd12;

    function automatic t_ctrl f_cw(t_op op, t_cond cond, logic [PC_W-1:0] target,
                                   logic last);
        t_ctrl w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    // Microprogram ROM
    function automatic t_ctrl f_ucode(logic [PC_W-1:0] pc);
        t_ctrl w;
        case (pc)
            ST_DIVC:  w = f_cw(OP_DIVC,  C_NEVER,    ST_DIVC,  1'b0);
            ST_MODR:  w = f_cw(OP_MODR,  C_NEVER,    ST_DIVC,  1'b0);
            ST_CHECK: w = f_cw(OP_CHECK, C_INVALID,  ST_EMIT,  1'b0);
            ST_ADD:   w = f_cw(OP_ADD,   C_NEVER,    ST_DIVC,  1'b0);
            ST_FWD:   w = f_cw(OP_FWD,   C_FWD,      ST_FWD,   1'b0);
            ST_BWD:   w = f_cw(OP_BWD,   C_BWD,      ST_BWD,   1'b0);
            ST_CLAMP: w = f_cw(OP_CLAMP, C_NEVER,    ST_DIVC,  1'b0);
            ST_ZPREP: w = f_cw(OP_ZPREP, C_NEVER,    ST_DIVC,  1'b0);
            ST_ZSUM1: w = f_cw(OP_ZSUM1, C_NEVER,    ST_DIVC,  1'b0);
            ST_ZSUM2: w = f_cw(OP_ZSUM2, C_NEVER,    ST_DIVC,  1'b0);
            ST_ZMUL:  w = f_cw(OP_ZMUL,  C_NEVER,    ST_DIVC,  1'b0);
            ST_ZMOD:  w = f_cw(OP_ZMOD,  C_NEVER,    ST_DIVC,  1'b0);
            ST_EMIT:  w = f_cw(OP_EMIT,  C_OUT_BUSY, ST_EMIT,  1'b1);
            default:  w = f_cw(OP_NOP,   C_NEVER,    ST_DIVC,  1'b1);
        endcase
        return w;
    endfunction

    // Year held as century and remainder: y = 100 * cent + rem
    function automatic logic f_is_leap(logic signed [CENT_W-1:0] cent,
                                       logic [REM_W-1:0] rem);
        return (rem != '0) ? (rem[1:0] == 2'b00) : (cent[1:0] == 2'b00);
    endfunction

    function automatic logic [DAY_W-1:0] f_days_in(logic [MONTH_W-1:0] month, logic leap);
        logic [DAY_W-1:0] d;
        case (month)
            4'd2:                    d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

    // floor(13 * (m + 1) / 5) for the shifted months 3..14
    function automatic logic [5:0] f_zeller_month(logic [MONTH_W-1:0] month);
        logic [5:0] t;
        case (month)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/gdo_if.sv
// Interfaces: valid/ready channels for the date item and the result word.
`timescale 1ns / 1ps

interface gdo_in_if;
    import gdo_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [DAY_W-1:0]           in_day;
    logic [MONTH_W-1:0]         in_month;
    logic [YEAR_W-1:0]          in_year;
    logic signed [OFFSET_W-1:0] day_offset;

    modport source (output valid, in_day, in_month, in_year, day_offset, input ready);
    modport sink   (input valid, in_day, in_month, in_year, day_offset, output ready);
endinterface

interface gdo_out_if;
    import gdo_pkg::*;
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;
    logic [WDAY_W-1:0]  weekday;
    logic               date_valid;
    logic               year_overflow;

    modport source (output valid, out_day, out_month, out_year, weekday, date_valid,
                    year_overflow, input ready);
    modport sink   (input valid, out_day, out_month, out_year, weekday, date_valid,
                    year_overflow, output ready);
endinterface

// File: rtl/gdo_sequencer.sv
// Sequencer: step counter, microprogram fetch and conditional jumps.
`timescale 1ns / 1ps

module gdo_sequencer import gdo_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    input  logic    i_out_busy,
    output logic    o_busy,
    output t_ctrl   o_ctrl
);

    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_busy, n_busy;
    t_ctrl           w_word;
    logic            w_take;

    assign w_word = f_ucode(r_pc);

    always_comb begin
        unique case (w_word.cond)
            C_NEVER:    w_take = 1'b0;
            C_INVALID:  w_take = i_status.bad;
            C_FWD:      w_take = i_status.fwd;
            C_BWD:      w_take = i_status.bwd;
            C_OUT_BUSY: w_take = i_out_busy;
            default:    w_take = 1'b0;
        endcase
    end

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = ST_DIVC;
            end
        end else if (w_take) begin
            n_pc = w_word.target;
        end else if (w_word.last) begin
            n_busy = 1'b0;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= ST_DIVC;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    always_comb begin
        o_ctrl = w_word;
        if (!r_busy) begin
            o_ctrl.op = OP_NOP;
        end
    end

    assign o_busy = r_busy;

endmodule

// File: rtl/gdo_datapath.sv
// Datapath: date registers, month stepper, clamp and weekday arithmetic.
`timescale 1ns / 1ps

module gdo_datapath import gdo_pkg::*; (
    input  logic    i_clk,
    input  logic    i_load,
    input  t_item   i_item,
    input  t_ctrl   i_ctrl,
    output t_status o_status,
    output t_result o_result
);

    logic signed [DACC_W-1:0]   r_d;
    logic [MONTH_W-1:0]         r_m;
    logic signed [YACC_W-1:0]   r_y;
    logic signed [CENT_W-1:0]   r_c;
    logic [REM_W-1:0]           r_r;
    logic signed [OFFSET_W-1:0] r_off;
    logic                       r_valid;
    logic                       r_ovf;
    logic [WDAY_W-1:0]          r_wd;
    logic [MONTH_W-1:0]         r_zm;
    logic [REM_W-1:0]           r_zk;
    logic [REM_W-1:0]           r_zj;
    logic [ZSUM_W-1:0]          r_s;
    logic [ZQ_W-1:0]            r_q;

    logic [DAY_W-1:0]           w_dim_cur;
    logic signed [DACC_W-1:0]   w_dim_cur_s;
    logic [MONTH_W-1:0]         w_m_prev;
    logic [REM_W-1:0]           w_r_prev;
    logic signed [CENT_W-1:0]   w_c_prev;
    logic [DAY_W-1:0]           w_dim_prev;
    logic [26:0]                w_cprod;
    logic [YEAR_W-1:0]          w_rdiff;
    logic [21:0]                w_qprod;
    logic [ZSUM_W-1:0]          w_h;

    assign w_dim_cur   = f_days_in(r_m, f_is_leap(r_c, r_r));
    assign w_dim_cur_s = $signed({{(DACC_W-DAY_W){1'b0}}, w_dim_cur});

    // Month before the current one, with year borrow
    assign w_m_prev   = (r_m == MONTH_JAN) ? MONTH_DEC : r_m - 1'b1;
    assign w_r_prev   = (r_r == '0) ? REM_MAX : r_r - 1'b1;
    assign w_c_prev   = (r_r == '0) ? r_c - CENT_W'(1) : r_c;
    assign w_dim_prev = (r_m == MONTH_JAN)
                      ? f_days_in(w_m_prev, f_is_leap(w_c_prev, w_r_prev))
                      : f_days_in(w_m_prev, f_is_leap(r_c, r_r));

    assign w_cprod = 27'(r_y[YEAR_W-1:0]) * 27'(RECIP_100);
    assign w_rdiff = r_y[YEAR_W-1:0] - YEAR_W'(r_c[7:0]) * YEAR_W'(CENTURY);
    assign w_qprod = 22'(r_s) * 22'(RECIP_7);
    assign w_h     = r_s - ZSUM_W'(r_q) * ZSUM_W'(WEEK);

    assign o_status.bad = !(r_y >= YEAR_MIN && r_y <= YEAR_MAX &&
                            r_m >= MONTH_JAN && r_m <= MONTH_DEC &&
                            r_d >= DACC_W'(1) && r_d <= w_dim_cur_s);
    assign o_status.fwd = r_d > w_dim_cur_s;
    assign o_status.bwd = r_d < DACC_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_d     <= $signed({{(DACC_W-DAY_W){1'b0}}, i_item.day});
            r_m     <= i_item.month;
            r_y     <= $signed({1'b0, i_item.year});
            r_off   <= i_item.offset;
            r_valid <= 1'b0;
            r_ovf   <= 1'b0;
            r_wd    <= '0;
        end else begin
            case (i_ctrl.op)
                OP_DIVC: begin
                    r_c <= $signed({1'b0, w_cprod[RECIP_100_SH +: 8]});
                end
                OP_MODR: begin
                    r_r <= w_rdiff[REM_W-1:0];
                end
                OP_CHECK: begin
                    r_valid <= !o_status.bad;
                end
                OP_ADD: begin
                    r_d <= r_d + DACC_W'(r_off);
                end
                OP_FWD: begin
                    if (o_status.fwd) begin
                        r_d <= r_d - w_dim_cur_s;
                        if (r_m == MONTH_DEC) begin
                            r_m <= MONTH_JAN;
                            r_y <= r_y + YACC_W'(1);
                            if (r_r == REM_MAX) begin
                                r_r <= '0;
                                r_c <= r_c + CENT_W'(1);
                            end else begin
                                r_r <= r_r + 1'b1;
                            end
                        end else begin
                            r_m <= r_m + 1'b1;
                        end
                    end
                end
                OP_BWD: begin
                    if (o_status.bwd) begin
                        r_d <= r_d + $signed({{(DACC_W-DAY_W){1'b0}}, w_dim_prev});
                        r_m <= w_m_prev;
                        if (r_m == MONTH_JAN) begin
                            r_y <= r_y - YACC_W'(1);
                            r_r <= w_r_prev;
                            r_c <= w_c_prev;
                        end
                    end
                end
                OP_CLAMP: begin
                    if (r_y > YEAR_MAX) begin
                        r_ovf <= 1'b1;
                        r_y   <= YEAR_MAX;
                        r_m   <= MONTH_DEC;
                        r_d   <= DACC_W'(31);
                        r_c   <= CENT_W'(99);
                        r_r   <= REM_MAX;
                    end else if (r_y < YEAR_MIN) begin
                        r_ovf <= 1'b1;
                        r_y   <= YEAR_MIN;
                        r_m   <= MONTH_JAN;
                        r_d   <= DACC_W'(1);
                        r_c   <= '0;
                        r_r   <= REM_W'(1);
                    end
                end
                OP_ZPREP: begin
                    // January and February count as months 13 and 14 of the year before
                    if (r_m < MONTH_MAR) begin
                        r_zm <= r_m + MONTH_W'(12);
                        r_zk <= w_r_prev;
                        r_zj <= w_c_prev[REM_W-1:0];
                    end else begin
                        r_zm <= r_m;
                        r_zk <= r_r;
                        r_zj <= r_c[REM_W-1:0];
                    end
                end
                OP_ZSUM1: begin
                    r_s <= ZSUM_W'(r_d[DAY_W-1:0]) + ZSUM_W'(f_zeller_month(r_zm))
                         + ZSUM_W'(r_zk) + ZSUM_W'(r_zk[REM_W-1:2]);
                end
                OP_ZSUM2: begin
                    r_s <= r_s + ZSUM_W'(r_zj[REM_W-1:2]) + ZSUM_W'({r_zj, 2'b00})
                         + ZSUM_W'(r_zj);
                end
                OP_ZMUL: begin
                    r_q <= w_qprod[RECIP_7_SH +: ZQ_W];
                end
                OP_ZMOD: begin
                    // Zeller gives 0 for Saturday; rotate so that Sunday is 0
                    r_wd <= (w_h[WDAY_W-1:0] == '0) ? WDAY_SAT
                                                    : w_h[WDAY_W-1:0] - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result.day           = r_d[DAY_W-1:0];
    assign o_result.month         = r_m;
    assign o_result.year          = r_y[YEAR_W-1:0];
    assign o_result.weekday       = r_wd;
    assign o_result.date_valid    = r_valid;
    assign o_result.year_overflow = r_ovf;

endmodule

// File: rtl/gregorian_date_offset_unit.sv
// Top level: Gregorian date plus day offset with weekday, microcoded sequencer and datapath.
`timescale 1ns / 1ps

// The unit takes one word (day, month, year, signed 16-bit day offset) at a time on
// i_item and returns one result word on o_res: the shifted date, its weekday (0 is
// Sunday), a flag that the input date was valid and a flag that the result year left
// 1..9999 and was held at 0001-01-01 or 9999-12-31. An invalid input date comes back
// unchanged with weekday 0 and both flags low. A short microprogram drives one shared
// datapath; the month stepper retires one month per cycle, and an invalid date goes
// straight from the check to the emit step. i_item.ready is high while the
// sequencer is idle; the result sits in an output register, so the next word is
// taken while the previous result still waits, and the sequencer holds at its
// last step only when that register is full and not being drained this cycle.

module gregorian_date_offset_unit import gdo_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gdo_in_if.sink    i_item,
    gdo_out_if.source o_res
);

    t_item   w_item;
    t_ctrl   w_ctrl;
    t_status w_status;
    t_result w_result;
    logic    w_busy;
    logic    w_accept;
    logic    w_out_busy;
    logic    w_emit;

    logic    r_out_valid;
    t_result r_out;

    // Accept a word only while the sequencer is idle
    assign i_item.ready = !w_busy;
    assign w_accept     = i_item.valid && !w_busy;

    assign w_item.day    = i_item.in_day;
    assign w_item.month  = i_item.in_month;
    assign w_item.year   = i_item.in_year;
    assign w_item.offset = i_item.day_offset;

    // Output register full and not being drained this cycle
    assign w_out_busy = r_out_valid && !o_res.ready;
    assign w_emit     = (w_ctrl.op == OP_EMIT) && !w_out_busy;

    gdo_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_status   (w_status),
        .i_out_busy (w_out_busy),
        .o_busy     (w_busy),
        .o_ctrl     (w_ctrl)
    );

    gdo_datapath u_dp (
        .i_clk    (i_clk),
        .i_load   (w_accept),
        .i_item   (w_item),
        .i_ctrl   (w_ctrl),
        .o_status (w_status),
        .o_result (w_result)
    );

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.out_day       = r_out.day;
    assign o_res.out_month     = r_out.month;
    assign o_res.out_year      = r_out.year;
    assign o_res.weekday       = r_out.weekday;
    assign o_res.date_valid    = r_out.date_valid;
    assign o_res.year_overflow = r_out.year_overflow;

endmodule

// File: rtl/gdo_checker.sv
// Checker: port-level assertions for the date offset unit, bound to the top level.
`timescale 1ns / 1ps

module gdo_checker import gdo_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [DAY_W-1:0]   i_out_day,
    input logic [MONTH_W-1:0] i_out_month,
    input logic [YEAR_W-1:0]  i_out_year,
    input logic [WDAY_W-1:0]  i_weekday,
    input logic               i_date_valid,
    input logic               i_year_overflow
);

    // One word in flight: the port closes right after a word is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input still ready after a word was taken");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_day) &&
        $stable(i_out_month) && $stable(i_out_year) && $stable(i_weekday) &&
        $stable(i_date_valid) && $stable(i_year_overflow))
        else $error("stalled result changed");

    // Invalid date: weekday zero, no overflow
    a_invalid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_date_valid |-> i_weekday == '0 && !i_year_overflow)
        else $error("invalid date with weekday or overflow set");

    // Valid date: weekday, month and year in range, day at least 1
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_date_valid |-> i_weekday <= WDAY_SAT &&
        i_out_month >= 4'd1 && i_out_month <= 4'd12 && i_out_day >= 5'd1 &&
        i_out_year >= 14'd1 && i_out_year <= 14'd9999)
        else $error("valid result out of calendar range");

    // Overflow holds the date at one of the two bounds
    a_overflow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_year_overflow |-> i_date_valid &&
        ((i_out_year == 14'd9999 && i_out_month == 4'd12 && i_out_day == 5'd31) ||
         (i_out_year == 14'd1 && i_out_month == 4'd1 && i_out_day == 5'd1)))
        else $error("overflow result not at a bound");

endmodule

bind gregorian_date_offset_unit gdo_checker u_gdo_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_item.valid),
    .i_in_ready      (i_item.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_day       (o_res.out_day),
    .i_out_month     (o_res.out_month),
    .i_out_year      (o_res.out_year),
    .i_weekday       (o_res.weekday),
    .i_date_valid    (o_res.date_valid),
    .i_year_overflow (o_res.year_overflow)
);
